// File: rtl/core/depth_to_color_reprojection_defines.svh
// Assertion macros shared by the reprojection RTL.
`ifndef DEPTH_TO_COLOR_REPROJECTION_DEFINES_SVH
`define DEPTH_TO_COLOR_REPROJECTION_DEFINES_SVH
`ifndef SYNTHESIS
`define D2C_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
`define D2C_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define D2C_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##(dly) (cons)) \
        else $error(msg);
`else
`define D2C_ASSERT(lbl, expr, msg)
`define D2C_ASSERT_IMPL(lbl, ante, cons, msg)
`define D2C_ASSERT_DELAY(lbl, ante, dly, cons, msg)
`endif
`endif

// File: rtl/core/d2c_pkg.sv
package d2c_pkg;

    localparam int CFG_NUM = 8;
    localparam int CFG_AW  = 5;

    typedef enum logic [2:0] {
        CFG_DEPTH_FX,
        CFG_DEPTH_FY,
        CFG_DEPTH_CX,
        CFG_DEPTH_CY,
        CFG_COLOR_FX,
        CFG_COLOR_FY,
        CFG_COLOR_CX,
        CFG_COLOR_CY
    } t_cfg_idx;

    localparam logic [15:0] CFG_RESET [CFG_NUM] = '{
        16'd6680, 16'd6694, 16'd5039, 16'd3012,
        16'd6680, 16'd6694, 16'd5039, 16'd3012
    };

    localparam logic [25:0] MM_TO_UM = 26'd1000;

    localparam logic signed [15:0] ROT_XX = 16'sd16384;
    localparam logic signed [15:0] ROT_XY = 16'sd17;
    localparam logic signed [15:0] ROT_XZ = -16'sd29;
    localparam logic signed [15:0] ROT_YX = -16'sd17;
    localparam logic signed [15:0] ROT_YY = 16'sd16384;
    localparam logic signed [15:0] ROT_YZ = -16'sd1;
    localparam logic signed [15:0] ROT_ZX = 16'sd29;
    localparam logic signed [15:0] ROT_ZY = 16'sd1;
    localparam logic signed [15:0] ROT_ZZ = 16'sd16384;
    localparam logic signed [15:0] ROUND_Q14 = 16'sd8192;

    localparam logic signed [15:0] TRANS_X = -16'sd13851;
    localparam logic signed [15:0] TRANS_Y = -16'sd220;
    localparam logic signed [15:0] TRANS_Z = -16'sd2053;

    localparam logic [16:0] CENTER_ROUND = 17'd8;

    localparam int BP_BITS = 42;
    localparam int PJ_BITS = 10;
    localparam int PJ_DEN  = 38;

    typedef struct packed {
        logic        neg;
        logic [25:0] z_um;
        logic [15:0] depth;
    } t_bp_side;

    typedef struct packed {
        logic        hit_pre;
        logic [15:0] depth;
    } t_pj_side;

endpackage

// File: rtl/core/d2c_div.sv
module d2c_div #(
    parameter int N = 42,
    parameter int M = 16,
    parameter int S = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [N-1:0] i_num,
    input  logic [M-1:0] i_rem,
    input  logic [M-1:0] i_den,
    input  logic [S-1:0] i_side,
    output logic         o_valid,
    output logic [N-1:0] o_quo,
    output logic [M-1:0] o_rem,
    output logic [S-1:0] o_side
);

    logic [N-1:0] r_vld;
    logic [M-1:0] r_rem  [N];
    logic [N-1:0] r_dq   [N];
    logic [M-1:0] r_den  [N];
    logic [S-1:0] r_side [N];
    logic [M-1:0] n_rem  [N];
    logic [N-1:0] n_dq   [N];

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic         s_vld;
        logic [M-1:0] s_rem;
        logic [M-1:0] s_den;
        logic [N-1:0] s_dq;
        logic [S-1:0] s_side;
        logic [M:0]   s_top;
        logic [M:0]   s_dif;

        if (s == 0) begin : g_first
            assign s_vld  = i_valid;
            assign s_rem  = i_rem;
            assign s_den  = i_den;
            assign s_dq   = i_num;
            assign s_side = i_side;
        end else begin : g_next
            assign s_vld  = r_vld[s-1];
            assign s_rem  = r_rem[s-1];
            assign s_den  = r_den[s-1];
            assign s_dq   = r_dq[s-1];
            assign s_side = r_side[s-1];
        end

        always_comb begin
            s_top    = {s_rem, s_dq[N-1]};
            s_dif    = s_top - {1'b0, s_den};
            n_rem[s] = s_dif[M] ? s_top[M-1:0] : s_dif[M-1:0];
            n_dq[s]  = {s_dq[N-2:0], ~s_dif[M]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= n_rem[s];
            r_dq[s]   <= n_dq[s];
            r_den[s]  <= s_den;
            r_side[s] <= s_side;
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_quo   = r_dq[N-1];
    assign o_rem   = r_rem[N-1];
    assign o_side  = r_side[N-1];

endmodule

// File: rtl/core/depth_to_color_reprojection.sv
// One depth pixel enters per clock and passes to o_done via the input stages, the two 42-step
// back-projection dividers, the transform stages, the two 10-step projection dividers and the
// output register. The receiver cannot stall the results, so busy stays low and no item waits.
`include "depth_to_color_reprojection_defines.svh"
module depth_to_color_reprojection
    import d2c_pkg::*;
#(
    parameter int COLOR_WIDTH  = 640,
    parameter int COLOR_HEIGHT = 480
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic [9:0]        i_pixel_col,
    input  logic [9:0]        i_pixel_row,
    input  logic [15:0]       i_depth_mm,
    output logic              o_done,
    output logic              o_hit,
    output logic [9:0]        o_color_col,
    output logic [9:0]        o_color_row,
    output logic [15:0]       o_depth_out
);

    localparam int LATENCY = BP_BITS + PJ_BITS + 10;

    logic [15:0] r_cfg [CFG_NUM];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_NUM; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (psel && penable && pwrite) begin
            r_cfg[paddr[4:2]] <= pwdata[15:0];
        end
    end

    assign prdata = {16'd0, r_cfg[paddr[4:2]]};
    assign pready = 1'b1;
    assign busy   = 1'b0;

    logic [15:0] w_fx_d, w_fy_d;
    assign w_fx_d = (r_cfg[CFG_DEPTH_FX] == 16'd0) ? 16'd1 : r_cfg[CFG_DEPTH_FX];
    assign w_fy_d = (r_cfg[CFG_DEPTH_FY] == 16'd0) ? 16'd1 : r_cfg[CFG_DEPTH_FY];

    // Offset from the principal point and depth in micrometres.
    logic        r_a_vld;
    logic [15:0] r_a_mag_x, r_a_mag_y;
    logic        r_a_neg_x, r_a_neg_y;
    logic [25:0] r_a_z;
    logic [15:0] r_a_d;
    logic [16:0] n_a_dx, n_a_dy;

    always_comb begin
        n_a_dx = {3'd0, i_pixel_col, 4'd0} - {1'b0, r_cfg[CFG_DEPTH_CX]};
        n_a_dy = {3'd0, i_pixel_row, 4'd0} - {1'b0, r_cfg[CFG_DEPTH_CY]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_neg_x <= n_a_dx[16];
        r_a_neg_y <= n_a_dy[16];
        r_a_mag_x <= n_a_dx[16] ? 16'(-n_a_dx) : n_a_dx[15:0];
        r_a_mag_y <= n_a_dy[16] ? 16'(-n_a_dy) : n_a_dy[15:0];
        r_a_z     <= 26'(i_depth_mm) * MM_TO_UM;
        r_a_d     <= i_depth_mm;
    end

    logic        r_b_vld;
    logic [41:0] r_b_px, r_b_py;
    logic        r_b_neg_x, r_b_neg_y;
    logic [25:0] r_b_z;
    logic [15:0] r_b_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_px    <= 42'(r_a_mag_x) * 42'(r_a_z);
        r_b_py    <= 42'(r_a_mag_y) * 42'(r_a_z);
        r_b_neg_x <= r_a_neg_x;
        r_b_neg_y <= r_a_neg_y;
        r_b_z     <= r_a_z;
        r_b_d     <= r_a_d;
    end

    t_bp_side             w_bx_side_in, w_bx_side;
    logic                 w_bx_vld, w_by_vld, w_by_neg;
    logic [BP_BITS-1:0]   w_bx_quo, w_by_quo;
    logic [15:0]          w_bx_rem, w_by_rem;

    assign w_bx_side_in = '{neg: r_b_neg_x, z_um: r_b_z, depth: r_b_d};

    d2c_div #(.N(BP_BITS), .M(16), .S($bits(t_bp_side))) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_vld),
        .i_num   (r_b_px),
        .i_rem   (16'd0),
        .i_den   (w_fx_d),
        .i_side  (w_bx_side_in),
        .o_valid (w_bx_vld),
        .o_quo   (w_bx_quo),
        .o_rem   (w_bx_rem),
        .o_side  (w_bx_side)
    );

    d2c_div #(.N(BP_BITS), .M(16), .S(1)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_vld),
        .i_num   (r_b_py),
        .i_rem   (16'd0),
        .i_den   (w_fy_d),
        .i_side  (r_b_neg_y),
        .o_valid (w_by_vld),
        .o_quo   (w_by_quo),
        .o_rem   (w_by_rem),
        .o_side  (w_by_neg)
    );

    // Floor of the signed quotient from magnitude and remainder.
    logic               r_c_vld;
    logic signed [43:0] r_c_x, r_c_y;
    logic [25:0]        r_c_z;
    logic [15:0]        r_c_d;
    logic [42:0]        n_c_mx, n_c_my;

    always_comb begin
        n_c_mx = {1'b0, w_bx_quo} + 43'(w_bx_side.neg && (w_bx_rem != 16'd0));
        n_c_my = {1'b0, w_by_quo} + 43'(w_by_neg && (w_by_rem != 16'd0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= w_bx_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_x <= w_bx_side.neg ? -$signed({1'b0, n_c_mx}) : $signed({1'b0, n_c_mx});
        r_c_y <= w_by_neg ? -$signed({1'b0, n_c_my}) : $signed({1'b0, n_c_my});
        r_c_z <= w_bx_side.z_um;
        r_c_d <= w_bx_side.depth;
    end

    logic               r_d_vld;
    logic signed [59:0] r_d_ax, r_d_ay, r_d_az;
    logic [15:0]        r_d_d;
    logic signed [59:0] n_d_ex, n_d_ey, n_d_ez;

    always_comb begin
        n_d_ex = r_c_x;
        n_d_ey = r_c_y;
        n_d_ez = $signed({34'd0, r_c_z});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_ax <= n_d_ex * ROT_XX + n_d_ey * ROT_XY + n_d_ez * ROT_XZ + ROUND_Q14;
        r_d_ay <= n_d_ex * ROT_YX + n_d_ey * ROT_YY + n_d_ez * ROT_YZ + ROUND_Q14;
        r_d_az <= n_d_ex * ROT_ZX + n_d_ey * ROT_ZY + n_d_ez * ROT_ZZ + ROUND_Q14;
        r_d_d  <= r_c_d;
    end

    logic               r_e_vld, r_e_pz_pos, r_e_nz;
    logic signed [44:0] r_e_px, r_e_py;
    logic [33:0]        r_e_pz;
    logic [15:0]        r_e_d;
    logic signed [59:0] n_e_sx, n_e_sy, n_e_sz;

    always_comb begin
        n_e_sx = (r_d_ax >>> 14) + TRANS_X;
        n_e_sy = (r_d_ay >>> 14) + TRANS_Y;
        n_e_sz = (r_d_az >>> 14) + TRANS_Z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_px     <= n_e_sx[44:0];
        r_e_py     <= n_e_sy[44:0];
        r_e_pz     <= n_e_sz[33:0];
        r_e_pz_pos <= !n_e_sz[59] && (n_e_sz != 60'sd0);
        r_e_nz     <= r_d_d != 16'd0;
        r_e_d      <= r_d_d;
    end

    // Projection products, split into partial products.
    logic               r_f_vld, r_f_pre;
    logic [38:0]        r_f_xl, r_f_yl;
    logic signed [38:0] r_f_xh, r_f_yh;
    logic [33:0]        r_f_cxl, r_f_cxh, r_f_cyl, r_f_cyh;
    logic [33:0]        r_f_pz;
    logic [15:0]        r_f_d;
    logic [16:0]        w_ccx, w_ccy;

    assign w_ccx = {1'b0, r_cfg[CFG_COLOR_CX]} + CENTER_ROUND;
    assign w_ccy = {1'b0, r_cfg[CFG_COLOR_CY]} + CENTER_ROUND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_xl  <= 39'(r_cfg[CFG_COLOR_FX]) * 39'(r_e_px[22:0]);
        r_f_yl  <= 39'(r_cfg[CFG_COLOR_FY]) * 39'(r_e_py[22:0]);
        r_f_xh  <= $signed({1'b0, r_cfg[CFG_COLOR_FX]}) * $signed(r_e_px[44:23]);
        r_f_yh  <= $signed({1'b0, r_cfg[CFG_COLOR_FY]}) * $signed(r_e_py[44:23]);
        r_f_cxl <= 34'(w_ccx) * 34'(r_e_pz[16:0]);
        r_f_cxh <= 34'(w_ccx) * 34'(r_e_pz[33:17]);
        r_f_cyl <= 34'(w_ccy) * 34'(r_e_pz[16:0]);
        r_f_cyh <= 34'(w_ccy) * 34'(r_e_pz[33:17]);
        r_f_pz  <= r_e_pz;
        r_f_pre <= r_e_nz && r_e_pz_pos;
        r_f_d   <= r_e_d;
    end

    logic               r_g_vld, r_g_pre;
    logic signed [61:0] r_g_ax, r_g_ay;
    logic [51:0]        r_g_bx, r_g_by;
    logic [33:0]        r_g_pz;
    logic [15:0]        r_g_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else begin
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_ax  <= (62'(r_f_xh) <<< 23) + $signed({23'd0, r_f_xl});
        r_g_ay  <= (62'(r_f_yh) <<< 23) + $signed({23'd0, r_f_yl});
        r_g_bx  <= ({18'd0, r_f_cxh} << 17) + {18'd0, r_f_cxl};
        r_g_by  <= ({18'd0, r_f_cyh} << 17) + {18'd0, r_f_cyl};
        r_g_pz  <= r_f_pz;
        r_g_pre <= r_f_pre;
        r_g_d   <= r_f_d;
    end

    logic               r_h_vld, r_h_pre;
    logic signed [61:0] r_h_nx, r_h_ny;
    logic [33:0]        r_h_pz;
    logic [15:0]        r_h_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else begin
            r_h_vld <= r_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_nx  <= r_g_ax + $signed({10'd0, r_g_bx});
        r_h_ny  <= r_g_ay + $signed({10'd0, r_g_by});
        r_h_pz  <= r_g_pz;
        r_h_pre <= r_g_pre;
        r_h_d   <= r_g_d;
    end

    // A quotient below 1024 leaves a remainder that starts below the divisor.
    logic              r_i_vld, r_i_okx, r_i_oky, r_i_pre;
    logic [47:0]       r_i_nx, r_i_ny;
    logic [PJ_DEN-1:0] r_i_den;
    logic [15:0]       r_i_d;
    logic [60:0]       w_i_lim;

    assign w_i_lim = 61'({r_h_pz, 14'd0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_vld <= 1'b0;
        end else begin
            r_i_vld <= r_h_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i_okx <= !r_h_nx[61] && (r_h_nx[60:0] < w_i_lim);
        r_i_oky <= !r_h_ny[61] && (r_h_ny[60:0] < w_i_lim);
        r_i_nx  <= r_h_nx[47:0];
        r_i_ny  <= r_h_ny[47:0];
        r_i_den <= {r_h_pz, 4'd0};
        r_i_pre <= r_h_pre;
        r_i_d   <= r_h_d;
    end

    t_pj_side              w_qc_side_in, w_qc_side;
    logic                  w_qc_vld, w_qr_vld, w_qr_ok;
    logic [PJ_BITS-1:0]    w_qc_quo, w_qr_quo;
    logic [PJ_DEN-1:0]     w_qc_rem, w_qr_rem;

    assign w_qc_side_in = '{hit_pre: r_i_pre && r_i_okx, depth: r_i_d};

    d2c_div #(.N(PJ_BITS), .M(PJ_DEN), .S($bits(t_pj_side))) u_div_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_i_vld),
        .i_num   (r_i_nx[PJ_BITS-1:0]),
        .i_rem   (r_i_nx[47:PJ_BITS]),
        .i_den   (r_i_den),
        .i_side  (w_qc_side_in),
        .o_valid (w_qc_vld),
        .o_quo   (w_qc_quo),
        .o_rem   (w_qc_rem),
        .o_side  (w_qc_side)
    );

    d2c_div #(.N(PJ_BITS), .M(PJ_DEN), .S(1)) u_div_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_i_vld),
        .i_num   (r_i_ny[PJ_BITS-1:0]),
        .i_rem   (r_i_ny[47:PJ_BITS]),
        .i_den   (r_i_den),
        .i_side  (r_i_oky),
        .o_valid (w_qr_vld),
        .o_quo   (w_qr_quo),
        .o_rem   (w_qr_rem),
        .o_side  (w_qr_ok)
    );

    logic        r_o_vld, r_o_hit;
    logic [9:0]  r_o_col, r_o_row;
    logic [15:0] r_o_d;
    logic        n_o_hit;

    always_comb begin
        n_o_hit = w_qc_side.hit_pre && w_qr_ok
                  && ({1'b0, w_qc_quo} < 11'(COLOR_WIDTH))
                  && ({1'b0, w_qr_quo} < 11'(COLOR_HEIGHT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
            r_o_hit <= 1'b0;
        end else begin
            r_o_vld <= w_qc_vld;
            r_o_hit <= w_qc_vld && n_o_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_col <= (w_qc_vld && n_o_hit) ? w_qc_quo : 10'd0;
        r_o_row <= (w_qc_vld && n_o_hit) ? w_qr_quo : 10'd0;
        r_o_d   <= w_qc_side.depth;
    end

    assign o_done      = r_o_vld;
    assign o_hit       = r_o_hit;
    assign o_color_col = r_o_col;
    assign o_color_row = r_o_row;
    assign o_depth_out = r_o_d;

    `D2C_ASSERT(a_bp_lockstep, w_bx_vld == w_by_vld, "back-projection dividers out of step")
    `D2C_ASSERT(a_pj_lockstep, w_qc_vld == w_qr_vld, "projection dividers out of step")
    `D2C_ASSERT_IMPL(a_hit_done, o_hit, o_done, "hit without a result transfer")
    `D2C_ASSERT_IMPL(a_miss_zero, !o_hit, o_color_col == 10'd0 && o_color_row == 10'd0, "miss with target")
    `D2C_ASSERT_DELAY(a_latency, start && !busy, LATENCY, o_done, "result missing after pixel transfer")

endmodule
